// ----- hw/rtl/indexed_list_insert_erase_assert.svh -----
// assertion macros for the list block
`ifndef INDEXED_LIST_INSERT_ERASE_ASSERT_SVH
`define INDEXED_LIST_INSERT_ERASE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ILIE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("list block assertion failed");

// next-cycle implication, checked outside reset
`define ILIE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("list block assertion failed");

`endif

// ----- hw/rtl/ilie_pkg.sv -----
`default_nettype none

package ilie_pkg;

    localparam int WORD_W       = 32;
    localparam int LEN_W        = 9;
    localparam int POS_W        = 9;
    localparam int CAPACITY_DEF = 256;
    localparam int CAPACITY_MAX = 65536;
    // wide enough for any position, length or index up to the largest capacity
    localparam int IDXC_W       = $clog2(CAPACITY_MAX + 1);
    // read select groups
    localparam int GRP_W        = 4;
    localparam int GRP          = 1 << GRP_W;

    typedef enum logic [2:0] {
        CMD_SET    = 3'd0,
        CMD_GET    = 3'd1,
        CMD_PUSH   = 3'd2,
        CMD_INSERT = 3'd3,
        CMD_ERASE  = 3'd4,
        CMD_RESIZE = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_FULL      = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_NONE,
        K_SET,
        K_INSERT,
        K_ERASE,
        K_FILL
    } t_kind;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_kind               kind;
        logic [IDXC_W-1:0]   lo;
        logic [IDXC_W-1:0]   hi;
        logic [WORD_W-1:0]   value;
    } t_cell_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/indexed_list_insert_erase.sv -----
// o_valid strobes for one cycle; it rises once a taken command has passed the registers
// r_v1 and r_valid in that order
// throughput: one command per cycle, busy never rises; every entry moves at once
// in the cell chain, and gets pass a two-level registered read select
// reset: synchronous active-low i_rst_n empties the list and drops results in flight
// entry contents are not cleared; the receiver cannot stall results
`default_nettype none
`include "indexed_list_insert_erase_assert.svh"

module indexed_list_insert_erase
    import ilie_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic        [2:0]        i_command,
    input  wire logic        [POS_W-1:0]  i_position,
    input  wire logic signed [WORD_W-1:0] i_value,
    input  wire logic        [LEN_W-1:0]  i_new_length,
    output logic                          o_valid,
    output logic signed      [WORD_W-1:0] o_read_value,
    output logic             [LEN_W-1:0]  o_length,
    output logic             [1:0]        o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NG    = ((CAPACITY + GRP - 1) / GRP < 2) ? 2 : (CAPACITY + GRP - 1) / GRP;
    localparam int AW    = $clog2(NG) + GRP_W;
    localparam logic [IDXC_W-1:0] CAP_W = IDXC_W'(CAPACITY);

    logic [CNT_W-1:0]  r_count;
    logic              r_v1;
    logic [LEN_W-1:0]  r_len1;
    t_status           r_st1;
    logic              r_valid;
    logic [LEN_W-1:0]  r_length;
    t_status           r_status;

    logic [IDXC_W-1:0] pos_w;
    logic [IDXC_W-1:0] cnt_w;
    logic [IDXC_W-1:0] req_w;
    logic [IDXC_W-1:0] n_cnt_w;
    t_status           st;
    t_cell_ctl         ctl;
    logic              rd_ok;
    logic [WORD_W-1:0] w_data [CAPACITY];
    logic [WORD_W-1:0] rd_word;

    assign pos_w = IDXC_W'(i_position);
    assign cnt_w = IDXC_W'(r_count);
    assign req_w = IDXC_W'(i_new_length);

    always_comb begin
        st        = ST_OK;
        ctl.kind  = K_NONE;
        ctl.lo    = pos_w;
        ctl.hi    = cnt_w;
        ctl.value = i_value;
        n_cnt_w   = cnt_w;
        rd_ok     = 1'b0;
        unique case (i_command)
            CMD_SET: begin
                if (pos_w < cnt_w) begin
                    ctl.kind = K_SET;
                end else begin
                    st = ST_RANGE;
                end
            end
            CMD_GET: begin
                if (pos_w < cnt_w) begin
                    rd_ok = 1'b1;
                end else begin
                    st = ST_RANGE;
                end
            end
            CMD_PUSH: begin
                if (cnt_w >= CAP_W) begin
                    st = ST_FULL;
                end else begin
                    ctl.kind = K_SET;
                    ctl.lo   = cnt_w;
                    n_cnt_w  = cnt_w + IDXC_W'(1);
                end
            end
            CMD_INSERT: begin
                priority if (pos_w > cnt_w) begin
                    st = ST_RANGE;
                end else if (cnt_w >= CAP_W) begin
                    st = ST_FULL;
                end else begin
                    ctl.kind = K_INSERT;
                    n_cnt_w  = cnt_w + IDXC_W'(1);
                end
            end
            CMD_ERASE: begin
                if (pos_w >= cnt_w) begin
                    st = ST_RANGE;
                end else begin
                    ctl.kind = K_ERASE;
                    ctl.hi   = cnt_w - IDXC_W'(1);
                    n_cnt_w  = cnt_w - IDXC_W'(1);
                end
            end
            CMD_RESIZE: begin
                if (req_w > CAP_W) begin
                    st = ST_TOO_LARGE;
                end else begin
                    // zero fill only touches cells between old and new end
                    ctl.kind = K_FILL;
                    ctl.lo   = cnt_w;
                    ctl.hi   = req_w;
                    n_cnt_w  = req_w;
                end
            end
            default: begin
                st = ST_OK;
            end
        endcase
        if (!start) begin
            ctl.kind = K_NONE;
            rd_ok    = 1'b0;
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] w_left;
        logic [WORD_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        ilie_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[g])
        );
    end

    ilie_rdsel #(
        .CAPACITY (CAPACITY),
        .NG       (NG),
        .AW       (AW)
    ) u_rdsel (
        .i_clk  (i_clk),
        .i_ok   (rd_ok),
        .i_addr (AW'(i_position)),
        .i_data (w_data),
        .o_word (rd_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v1    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (start) begin
                r_count <= CNT_W'(n_cnt_w);
            end
            r_v1    <= start;
            r_valid <= r_v1;
        end
        r_len1   <= LEN_W'(n_cnt_w);
        r_st1    <= st;
        r_length <= r_len1;
        r_status <= r_st1;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_valid;
    assign o_read_value = rd_word;
    assign o_length     = r_length;
    assign o_status     = r_status;

    `ILIE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(CAPACITY))
    `ILIE_ASSERT_NXT(a_idle_count, !start, $stable(r_count))
    `ILIE_ASSERT_NXT(a_stage_one, start, r_v1)
    `ILIE_ASSERT_NXT(a_stage_two, r_v1, r_valid)
    `ILIE_ASSERT_IMP(a_fail_zero, r_valid && r_status != ST_OK, rd_word == '0)

endmodule

`default_nettype wire

// ----- hw/rtl/ilie_cell.sv -----
`default_nettype none

module ilie_cell
    import ilie_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic [WORD_W-1:0] i_left,
    input  wire logic [WORD_W-1:0] i_right,
    output logic      [WORD_W-1:0] o_data
);

    localparam logic [IDXC_W-1:0] ME = IDXC_W'(IDX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_ctl.kind)
            K_SET: begin
                if (ME == i_ctl.lo) begin
                    n_data = i_ctl.value;
                end
            end
            K_INSERT: begin
                // entries from the position up to the old end move one place up
                if (ME == i_ctl.lo) begin
                    n_data = i_ctl.value;
                end else if (ME > i_ctl.lo && ME <= i_ctl.hi) begin
                    n_data = i_left;
                end
            end
            K_ERASE: begin
                if (ME >= i_ctl.lo && ME < i_ctl.hi) begin
                    n_data = i_right;
                end
            end
            K_FILL: begin
                if (ME >= i_ctl.lo && ME < i_ctl.hi) begin
                    n_data = '0;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ----- hw/rtl/ilie_rdsel.sv -----
`default_nettype none

module ilie_rdsel
    import ilie_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int NG       = ((CAPACITY + GRP - 1) / GRP < 2) ? 2 : (CAPACITY + GRP - 1) / GRP,
    parameter int AW       = $clog2(NG) + GRP_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_ok,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [WORD_W-1:0] i_data [CAPACITY],
    output logic      [WORD_W-1:0] o_word
);

    localparam int HW   = AW - GRP_W;
    localparam int PADN = NG * GRP;

    logic [WORD_W-1:0] w_pad [PADN];
    logic [WORD_W-1:0] r_grp [NG];
    logic [WORD_W-1:0] n_grp [NG];
    logic [HW-1:0]     r_hi;
    logic              r_ok;
    logic [WORD_W-1:0] r_word;

    for (genvar k = 0; k < PADN; k++) begin : g_pad
        if (k < CAPACITY) begin : g_real
            assign w_pad[k] = i_data[k];
        end else begin : g_zero
            assign w_pad[k] = '0;
        end
    end

    // first level: pick the low address bits inside every group
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = w_pad[{HW'(g), i_addr[GRP_W-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp <= n_grp;
        r_hi  <= i_addr[AW-1:GRP_W];
        r_ok  <= i_ok;
        r_word <= r_ok ? r_grp[r_hi] : '0;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire
